[design/i2cmw_pkg.sv]
// Shared types and constants of the I2C master write sequencer.
package i2cmw_pkg;

  // Default transmit buffer depth in bytes
  localparam int unsigned BufDepthDefault = 16;

  // Field widths of one input beat and one result beat
  localparam int unsigned CmdW     = 2;
  localparam int unsigned PosW     = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 7;
  localparam int unsigned LenW     = 5;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  // Input command codes
  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Transaction phase codes
  typedef enum logic [PhaseW-1:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TX    = 3'd3,
    PH_STOP  = 3'd4,
    PH_ERROR = 3'd5
  } phase_t;

  // Controller status flags of one event
  typedef struct packed {
    logic nack;
    logic tx_empty;
    logic addr_acked;
    logic start_sent;
  } status_t;

  // One result beat
  typedef struct packed {
    logic             busy_res;
    logic [PhaseW-1:0] phase;
    logic             stop_request;
    logic [ByteW-1:0] write_byte;
    logic             write_valid;
  } result_t;

endpackage

[design/i2cmw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module i2cmw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/i2cmw_ctrl.sv]
// Transaction state, transmit buffer and per-beat result logic.
module i2cmw_ctrl
  import i2cmw_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = BufDepthDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  cmd_t             cmd,
  input  logic [PosW-1:0]  load_position,
  input  logic [ByteW-1:0] load_byte,
  input  logic [AddrW-1:0] dest_address,
  input  logic [LenW-1:0]  txn_length,
  input  status_t          status,
  output result_t          result
);

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned PW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned LW = (PW > LenW) ? PW : LenW;

  phase_t           phase_r, phase_nxt;
  logic             active_r, active_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [PW-1:0]    count_r, count_nxt;
  logic [AddrW-1:0] taddr_r, taddr_nxt;
  logic             byp_hit_r, byp_hit_nxt;
  logic [ByteW-1:0] byp_data_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [ByteW-1:0] rd_data;
  logic [ByteW-1:0] cur_byte;
  logic [LW-1:0]    len_ext;

  // Buffer keeps the slot at the current position on its read port
  i2cmw_ram #(
    .WIDTH (ByteW),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (load_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Drop loads beyond the buffer
  assign wr_en   = take && (cmd == CMD_LOAD) && (32'(load_position) < BUF_DEPTH);
  assign wr_addr = AW'(load_position);
  assign rd_addr = pos_nxt[AW-1:0];

  // Forward a load that lands on the slot being read in the same cycle
  assign byp_hit_nxt = wr_en && (wr_addr == rd_addr);
  assign cur_byte    = byp_hit_r ? byp_data_r : rd_data;
  assign len_ext     = LW'(txn_length);

  // Next state and result of the accepted beat
  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    taddr_nxt  = taddr_r;
    result     = '0;
    if (take) begin
      unique case (cmd)
        CMD_START: begin
          taddr_nxt  = dest_address;
          count_nxt  = (len_ext > LW'(BUF_DEPTH)) ? PW'(BUF_DEPTH) : PW'(len_ext);
          pos_nxt    = '0;
          phase_nxt  = PH_START;
          active_nxt = 1'b1;
        end
        CMD_EVENT: begin
          if (active_r) begin
            if (status.nack) begin
              result.stop_request = 1'b1;
              phase_nxt           = PH_ERROR;
            end else begin
              unique case (phase_r)
                PH_START: begin
                  if (status.start_sent) begin
                    result.write_valid = 1'b1;
                    result.write_byte  = {taddr_r, 1'b0};
                    phase_nxt          = PH_ADDR;
                  end
                end
                PH_ADDR: begin
                  if (status.addr_acked) begin
                    if (count_r != '0) begin
                      result.write_valid = 1'b1;
                      result.write_byte  = cur_byte;
                      pos_nxt            = pos_r + PW'(1);
                      phase_nxt          = PH_TX;
                    end else begin
                      result.stop_request = 1'b1;
                      phase_nxt           = PH_STOP;
                    end
                  end
                end
                PH_TX: begin
                  if (status.tx_empty) begin
                    if (pos_r < count_r) begin
                      result.write_valid = 1'b1;
                      result.write_byte  = cur_byte;
                      pos_nxt            = pos_r + PW'(1);
                    end else begin
                      result.stop_request = 1'b1;
                      phase_nxt           = PH_STOP;
                    end
                  end
                end
                PH_STOP: begin
                  phase_nxt  = PH_IDLE;
                  active_nxt = 1'b0;
                end
                default: begin
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
    result.phase    = phase_nxt;
    result.busy_res = active_nxt;
  end

  // Hold transaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      active_r  <= 1'b0;
      pos_r     <= '0;
      count_r   <= '0;
      taddr_r   <= '0;
      byp_hit_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      active_r  <= active_nxt;
      pos_r     <= pos_nxt;
      count_r   <= count_nxt;
      taddr_r   <= taddr_nxt;
      byp_hit_r <= byp_hit_nxt;
    end
  end

  // Capture forwarded load data
  always_ff @(posedge clk) begin
    byp_data_r <= load_byte;
  end

endmodule

[design/i2c_master_write_sequencer.sv]
// Top level of the I2C master write sequencer: input unpacking and result register.
//
// Usage: every input beat on in_* is a command for the sequencer. in_tuser
// carries the command (load buffer byte, start transaction, status event,
// no operation) and in_tdata its operands and the controller status flags.
// Each accepted beat yields exactly one result beat on out_*: the byte to
// hand to the byte-level controller (if any), a STOP request, the phase and
// the active flag after the beat.
// Latency: the result of a beat is valid on out_* in the cycle after it is
// accepted. Throughput: one beat per cycle while out_tready keeps the result
// register draining; the whole update is combinational logic between the input
// handshake and the result register, and the RAM read port is fed the next position.
// Stall: a single result register holds the pending beat; in_tready stays
// high while that register is empty or being drained in the same cycle, and
// drops while out_tready is low with a result waiting.
// Reset: rst_n (synchronous, active low) returns to the idle phase with the
// transaction inactive and no result pending. Buffer contents are not
// cleared; a slot must be loaded before a transaction sends it.
module i2c_master_write_sequencer
  import i2cmw_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = BufDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [3:0] load_position, [11:4] load_byte, [18:12] dest_address,
  // [23:19] txn_length, [24] flag_start_sent, [25] flag_addr_acked,
  // [26] flag_tx_empty, [27] flag_nack, [31:28] zero
  input  logic [InDataW-1:0]  in_tdata,
  // [1:0] command
  input  logic [CmdW-1:0]     in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] write_valid, [8:1] write_byte, [9] stop_request, [12:10] phase,
  // [13] busy_res, [15:14] zero
  output logic [OutDataW-1:0] out_tdata
);

  logic    take;
  status_t status;
  result_t result;
  result_t res_r;
  logic    out_valid_r;

  // Accept while the result register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;

  assign status.start_sent = in_tdata[24];
  assign status.addr_acked = in_tdata[25];
  assign status.tx_empty   = in_tdata[26];
  assign status.nack       = in_tdata[27];

  i2cmw_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .cmd           (cmd_t'(in_tuser)),
    .load_position (in_tdata[3:0]),
    .load_byte     (in_tdata[11:4]),
    .dest_address  (in_tdata[18:12]),
    .txn_length    (in_tdata[23:19]),
    .status        (status),
    .result        (result)
  );

  // Track a pending result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result register on each accepted beat
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'(res_r);

endmodule

[verif/i2c_master_write_sequencer_test.sv]
// Self-checking testbench of the I2C master write sequencer: directed and random beats.
module i2c_master_write_sequencer_test;
  import i2cmw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BufDepth = BufDepthDefault;
  localparam int unsigned MaxGap = 18;
  localparam int unsigned RandomBeats = 700;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic [CmdW-1:0]     in_tuser;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic [OutDataW-1:0] out_tdata;

  // Sequencer mirror used to predict each result beat
  phase_t           seq_phase;
  logic             txn_active;
  logic [LenW-1:0]  next_slot;
  logic [LenW-1:0]  txn_len;
  logic [AddrW-1:0] txn_addr;
  logic [ByteW-1:0] tx_mem [BufDepth];
  bit               slot_loaded [BufDepth];

  result_t beat_exp_q [$];
  int      n_errors = 0;
  int      n_results = 0;
  int      n_counted = 0;
  bit      src_pace = 1'b1;
  bit      sink_pace = 1'b1;
  bit      sink_took = 1'b0;
  int      sink_wait = 0;

  i2c_master_write_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5ns clk = ~clk;

  // Bound the run in case the block hangs
  initial begin
    #3ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("ERROR at %0t, result %0d: %s expected %0h got %0h",
             $realtime, n_results, what, want, got);
    n_errors++;
  endtask

  // Advance the mirror by one accepted beat and return the expected result
  function automatic result_t predict_beat(input cmd_t c, input logic [InDataW-1:0] d);
    result_t         r;
    status_t         st;
    logic [LenW-1:0] len;
    r = '0;
    st = d[27:24];
    len = d[23:19];
    case (c)
      CMD_LOAD: begin
        tx_mem[d[3:0]] = d[11:4];
        slot_loaded[d[3:0]] = 1'b1;
      end
      CMD_START: begin
        if (len > BufDepth) len = LenW'(BufDepth);
        txn_addr = d[18:12];
        txn_len = len;
        next_slot = '0;
        seq_phase = PH_START;
        txn_active = 1'b1;
      end
      CMD_EVENT: begin
        if (txn_active && st.nack) begin
          r.stop_request = 1'b1;
          seq_phase = PH_ERROR;
        end else if (txn_active) begin
          case (seq_phase)
            PH_START: begin
              if (st.start_sent) begin
                r.write_valid = 1'b1;
                r.write_byte = {txn_addr, 1'b0};
                seq_phase = PH_ADDR;
              end
            end
            PH_ADDR: begin
              if (st.addr_acked && txn_len != 0) begin
                r.write_valid = 1'b1;
                r.write_byte = tx_mem[next_slot[3:0]];
                next_slot++;
                seq_phase = PH_TX;
              end else if (st.addr_acked) begin
                r.stop_request = 1'b1;
                seq_phase = PH_STOP;
              end
            end
            PH_TX: begin
              if (st.tx_empty && next_slot < txn_len) begin
                r.write_valid = 1'b1;
                r.write_byte = tx_mem[next_slot[3:0]];
                next_slot++;
              end else if (st.tx_empty) begin
                r.stop_request = 1'b1;
                seq_phase = PH_STOP;
              end
            end
            PH_STOP: begin
              seq_phase = PH_IDLE;
              txn_active = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    r.phase = seq_phase;
    r.busy_res = txn_active;
    return r;
  endfunction

  // Drive one beat after a random gap and wait for its handshake
  task automatic send_beat(input cmd_t c, input logic [InDataW-1:0] d);
    int gap;
    gap = src_pace ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!(c == CMD_EVENT && !txn_active)) n_counted++;
    beat_exp_q.push_back(predict_beat(c, d));
  endtask

  // Random filler in every field the command does not use
  function automatic logic [InDataW-1:0] noise_word();
    logic [31:0] w;
    w = $urandom;
    return {4'b0, w[27:0]};
  endfunction

  task automatic do_load(input logic [PosW-1:0] pos, input logic [ByteW-1:0] b);
    logic [InDataW-1:0] d;
    d = noise_word();
    d[3:0] = pos;
    d[11:4] = b;
    send_beat(CMD_LOAD, d);
  endtask

  task automatic do_start(input logic [AddrW-1:0] addr, input logic [LenW-1:0] len);
    logic [InDataW-1:0] d;
    d = noise_word();
    d[18:12] = addr;
    d[23:19] = len;
    send_beat(CMD_START, d);
  endtask

  task automatic do_event(input status_t st);
    logic [InDataW-1:0] d;
    d = noise_word();
    d[27:24] = st;
    send_beat(CMD_EVENT, d);
  endtask

  task automatic do_nop();
    send_beat(CMD_NOP, noise_word());
  endtask

  // Fill every slot a transaction of this length reads that was never loaded
  task automatic load_missing(input logic [LenW-1:0] len);
    int upto;
    upto = (len > BufDepth) ? BufDepth : len;
    for (int i = 0; i < upto; i++) begin
      if (!slot_loaded[i]) do_load(PosW'(i), ByteW'($urandom_range(0, 255)));
    end
  endtask

  // Hold the input until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (beat_exp_q.size() != 0) @(posedge clk);
  endtask

  // Walk one write transaction; with noise, add stray flags, NACKs, no-ops, loads and aborts
  task automatic run_write(input logic [AddrW-1:0] addr, input logic [LenW-1:0] len,
                           input bit noisy);
    status_t st;
    int      steps;
    logic [3:0] bits;
    load_missing(len);
    do_start(addr, len);
    steps = 0;
    while (txn_active && seq_phase != PH_IDLE && seq_phase != PH_ERROR && steps < 40) begin
      bits = 4'($urandom);
      st = noisy ? status_t'({1'b0, bits[2:0]}) : '0;
      case (seq_phase)
        PH_START: st.start_sent = 1'b1;
        PH_ADDR:  st.addr_acked = 1'b1;
        PH_TX:    st.tx_empty = 1'b1;
        default: begin
        end
      endcase
      if (noisy && $urandom_range(0, 9) == 0) begin
        st.start_sent = 1'b0;
        st.addr_acked = 1'b0;
        st.tx_empty = 1'b0;
      end
      st.nack = noisy && $urandom_range(0, 29) == 0;
      if (noisy && $urandom_range(0, 29) == 0) do_nop();
      if (noisy && $urandom_range(0, 29) == 0)
        do_load(PosW'($urandom_range(0, 15)), ByteW'($urandom));
      if (noisy && $urandom_range(0, 49) == 0) break;
      do_event(st);
      steps++;
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      sink_took = 1'b1;
      got = out_tdata[$bits(result_t)-1:0];
      if (beat_exp_q.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 32'(got));
      end else begin
        want = beat_exp_q.pop_front();
        if (got.write_valid !== want.write_valid)
          report_mismatch("write_valid", 32'(want.write_valid), 32'(got.write_valid));
        if (got.write_byte !== want.write_byte)
          report_mismatch("write_byte", 32'(want.write_byte), 32'(got.write_byte));
        if (got.stop_request !== want.stop_request)
          report_mismatch("stop_request", 32'(want.stop_request), 32'(got.stop_request));
        if (got.phase !== want.phase)
          report_mismatch("phase", 32'(want.phase), 32'(got.phase));
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      end
      n_results++;
    end
  end

  // Stall the result side for a random number of cycles after each beat
  always @(negedge clk) begin
    if (sink_took) begin
      sink_took = 1'b0;
      sink_wait = sink_pace ? $urandom_range(0, MaxGap) : 0;
    end
    if (sink_wait > 0) begin
      out_tready <= 1'b0;
      sink_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Events while inactive and the no-op command leave the state alone
  task automatic test_inactive_events();
    do_event(4'hF);
    do_event(4'h0);
    do_nop();
  endtask

  // Zero length goes straight from the address phase to STOP
  task automatic test_zero_length();
    do_start(7'h7F, 5'd0);
    do_event(4'b0001);
    do_event(4'b0010);
    do_event(4'b0000);
    do_event(4'b0111);
  endtask

  // Short write with extreme bytes, stray flags and several flags per event
  task automatic test_data_write();
    do_load(4'd0, 8'h00);
    do_load(4'd1, 8'hFF);
    do_load(4'd15, 8'hA5);
    do_start(7'h00, 5'd2);
    do_event(4'b0100);
    do_event(4'b0111);
    do_event(4'b0111);
    do_event(4'b0100);
    do_event(4'b0100);
    do_event(4'b0111);
  endtask

  // NACK parks in error; a new start drops whatever runs
  task automatic test_nack_restart();
    load_missing(5'd3);
    do_start(7'h55, 5'd3);
    do_event(4'b0001);
    do_event(4'b1111);
    do_event(4'b0100);
    do_start(7'h2A, 5'd1);
    do_event(4'b0001);
    do_start(7'h01, 5'd2);
    do_event(4'b0001);
    do_event(4'b0010);
    do_event(4'b1100);
  endtask

  // Mostly well-formed transactions with random content, plus noise
  task automatic test_random_traffic();
    int target;
    logic [LenW-1:0] len;
    logic [InDataW-1:0] d;
    cmd_t c;
    target = n_counted + RandomBeats;
    while (n_counted < target) begin
      if ($urandom_range(0, 15) == 0) begin
        src_pace = $urandom_range(0, 3) != 0;
        sink_pace = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 59) == 0) drain_results();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          case ($urandom_range(0, 9))
            0:       len = LenW'($urandom_range(17, 31));
            1:       len = 5'd16;
            default: len = LenW'($urandom_range(0, 15));
          endcase
          run_write(AddrW'($urandom), len, $urandom_range(0, 2) != 0);
        end
        7: do_load(PosW'($urandom), ByteW'($urandom));
        8: begin
          d = noise_word();
          c = cmd_t'($urandom_range(0, 3));
          if (c == CMD_START) load_missing(d[23:19]);
          send_beat(c, d);
        end
        default: begin
          do_nop();
          do_event(status_t'(4'($urandom)));
        end
      endcase
    end
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (beat_exp_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (beat_exp_q.size() != 0)
      report_mismatch("results never delivered", beat_exp_q.size(), 0);
  endtask

  initial begin
    seq_phase = PH_IDLE;
    txn_active = 1'b0;
    next_slot = '0;
    txn_len = '0;
    txn_addr = '0;
    for (int i = 0; i < BufDepth; i++) begin
      tx_mem[i] = '0;
      slot_loaded[i] = 1'b0;
    end
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_NOP;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_inactive_events();
    test_zero_length();
    test_data_write();
    test_nack_restart();
    drain_results();
    test_random_traffic();
    finish_run();

    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[i2c_master_write_sequencer.f]
design/i2cmw_pkg.sv
design/i2cmw_ram.sv
design/i2cmw_ctrl.sv
design/i2c_master_write_sequencer.sv
verif/i2c_master_write_sequencer_test.sv
